>>> hdl/rhs_pkg.sv
// Shared types and constants for the RTP header strip block.
package rhs_pkg;

    localparam int unsigned FIXED_LEN = 12;
    localparam int unsigned BL_W      = 18;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = 1;
    localparam int unsigned Q_CNT_W   = 2;

    typedef enum logic [2:0] {
        SEC_FIXED,
        SEC_CSRC,
        SEC_EXTHDR,
        SEC_EXTDATA,
        SEC_PAYLOAD
    } rhs_section_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT_FIXED,
        ST_SHORT_CSRC,
        ST_NO_EXT_HDR,
        ST_SHORT_EXT
    } rhs_status_t;

    typedef logic [FIXED_LEN-1:0][7:0] rhs_hdr_t;

    // One result as it travels from the parser to the output stage.
    typedef struct packed {
        logic [7:0]  data;
        logic        data_valid;
        logic        eop;
        rhs_status_t status;
        rhs_hdr_t    hdr;
    } rhs_entry_t;

    typedef struct packed {
        logic       push;
        rhs_entry_t entry;
    } rhs_push_t;

endpackage

>>> hdl/rhs_if.sv
// Valid/ready channel interfaces for packet bytes in and results out.
interface rhs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface rhs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_packet;
    logic [2:0]  status;
    logic [1:0]  rtp_version;
    logic        marker_bit;
    logic [6:0]  payload_type;
    logic [15:0] seq_number;
    logic [31:0] media_timestamp;
    logic [31:0] source_id;

    modport source (
        output valid, output out_byte, output byte_valid, output end_of_packet,
        output status, output rtp_version, output marker_bit, output payload_type,
        output seq_number, output media_timestamp, output source_id,
        input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input end_of_packet,
        input status, input rtp_version, input marker_bit, input payload_type,
        input seq_number, input media_timestamp, input source_id,
        output ready
    );
endinterface

>>> hdl/rhs_front.sv
// Header parser: walks the RTP header sections and raises one result per item that needs it.
module rhs_front
    import rhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output rhs_push_t  push
);

    rhs_section_t    sec_reg, sec_next;
    logic [BL_W-1:0] bl_reg, bl_next;
    logic            hasx_reg, hasx_next;
    logic [15:0]     ext_reg, ext_next;
    rhs_hdr_t        hdr_reg;
    rhs_hdr_t        hdr_cur;
    logic [3:0]      idx;
    logic [2:0]      pos;
    logic            hdr_we;

    assign idx    = 4'(FIXED_LEN) - bl_reg[3:0];
    assign pos    = 3'd4 - bl_reg[2:0];
    assign hdr_we = accept && (sec_reg == SEC_FIXED);

    // Header bytes as they stand after this item, including the one arriving now.
    always_comb
    begin
        hdr_cur = hdr_reg;
        if (hdr_we)
        begin
            hdr_cur[idx] = in_byte;
        end
    end

    always_comb
    begin
        sec_next   = sec_reg;
        bl_next    = bl_reg;
        hasx_next  = hasx_reg;
        ext_next   = ext_reg;
        push       = '0;
        push.entry.hdr = hdr_cur;
        if (accept)
        begin
            if (sec_reg == SEC_PAYLOAD)
            begin
                push.push             = 1'b1;
                push.entry.data       = in_byte;
                push.entry.data_valid = 1'b1;
                push.entry.eop        = last_byte;
                push.entry.status     = ST_OK;
            end
            else
            begin
                if (sec_reg == SEC_EXTHDR)
                begin
                    if (pos == 3'd2)
                    begin
                        ext_next = {in_byte, 8'h00};
                    end
                    else if (pos == 3'd3)
                    begin
                        ext_next = {ext_reg[15:8], in_byte};
                    end
                end
                bl_next = bl_reg - BL_W'(1);

                // Pass over every section that is now exhausted, empty ones included.
                if (bl_next == '0 && sec_next == SEC_FIXED)
                begin
                    hasx_next = hdr_cur[0][4];
                    bl_next   = BL_W'({hdr_cur[0][3:0], 2'b00});
                    sec_next  = SEC_CSRC;
                end
                if (bl_next == '0 && sec_next == SEC_CSRC)
                begin
                    if (hasx_next)
                    begin
                        sec_next = SEC_EXTHDR;
                        bl_next  = BL_W'(4);
                    end
                    else
                    begin
                        sec_next = SEC_PAYLOAD;
                    end
                end
                if (bl_next == '0 && sec_next == SEC_EXTHDR)
                begin
                    bl_next  = BL_W'({ext_next, 2'b00});
                    sec_next = SEC_EXTDATA;
                end
                if (bl_next == '0 && sec_next == SEC_EXTDATA)
                begin
                    sec_next = SEC_PAYLOAD;
                end

                if (last_byte)
                begin
                    push.push = 1'b1;
                    push.entry.eop = 1'b1;
                    unique case (sec_next)
                        SEC_PAYLOAD: push.entry.status = ST_OK;
                        SEC_FIXED:   push.entry.status = ST_SHORT_FIXED;
                        SEC_CSRC:    push.entry.status = ST_SHORT_CSRC;
                        SEC_EXTHDR:  push.entry.status = ST_NO_EXT_HDR;
                        default:     push.entry.status = ST_SHORT_EXT;
                    endcase
                end
            end

            // Restart on the end of any packet.
            if (last_byte)
            begin
                sec_next  = SEC_FIXED;
                bl_next   = BL_W'(FIXED_LEN);
                hasx_next = 1'b0;
                ext_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg  <= SEC_FIXED;
            bl_reg   <= BL_W'(FIXED_LEN);
            hasx_reg <= 1'b0;
            ext_reg  <= '0;
        end
        else
        begin
            sec_reg  <= sec_next;
            bl_reg   <= bl_next;
            hasx_reg <= hasx_next;
            ext_reg  <= ext_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_reg[idx] <= in_byte;
        end
    end

endmodule

>>> hdl/rhs_queue.sv
// Two-entry result queue between the parser and the output stage.
module rhs_queue
    import rhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rhs_push_t  push,
    output logic       full,
    output logic       q_valid,
    output rhs_entry_t q_entry,
    input  logic       pop
);

    rhs_entry_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, rd_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.push && !pop)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (!push.push && pop)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.push)
            begin
                wr_reg <= wr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_reg] <= push.entry;
        end
    end

endmodule

>>> hdl/rhs_back.sv
// Output stage: formats queued results into header fields and holds them for the sink.
module rhs_back
    import rhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  rhs_entry_t q_entry,
    output logic       pop,
    rhs_out_if.source  tx
);

    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        bv_reg, eop_reg;
    logic [2:0]  status_reg;
    logic [1:0]  ver_reg;
    logic        mark_reg;
    logic [6:0]  pt_reg;
    logic [15:0] seq_reg;
    logic [31:0] ts_reg, ssrc_reg;
    rhs_hdr_t    h;
    logic        zero_hdr;

    assign pop      = q_valid && (!valid_reg || tx.ready);
    assign h        = q_entry.hdr;
    // A packet that ends inside the fixed header reports no header fields.
    assign zero_hdr = (q_entry.status == ST_SHORT_FIXED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || tx.ready)
        begin
            valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg   <= q_entry.data;
            bv_reg     <= q_entry.data_valid;
            eop_reg    <= q_entry.eop;
            status_reg <= q_entry.status;
            ver_reg    <= zero_hdr ? 2'b00 : h[0][7:6];
            mark_reg   <= zero_hdr ? 1'b0 : h[1][7];
            pt_reg     <= zero_hdr ? 7'h00 : h[1][6:0];
            seq_reg    <= zero_hdr ? 16'h0000 : {h[2], h[3]};
            ts_reg     <= zero_hdr ? 32'h0 : {h[4], h[5], h[6], h[7]};
            ssrc_reg   <= zero_hdr ? 32'h0 : {h[8], h[9], h[10], h[11]};
        end
    end

    assign tx.valid           = valid_reg;
    assign tx.out_byte        = byte_reg;
    assign tx.byte_valid      = bv_reg;
    assign tx.end_of_packet   = eop_reg;
    assign tx.status          = status_reg;
    assign tx.rtp_version     = ver_reg;
    assign tx.marker_bit      = mark_reg;
    assign tx.payload_type    = pt_reg;
    assign tx.seq_number      = seq_reg;
    assign tx.media_timestamp = ts_reg;
    assign tx.source_id       = ssrc_reg;

endmodule

>>> hdl/rtp_header_strip.sv
// RTP header strip: accepts one packet byte per item, with last_byte marking the final
// byte, and takes in a new item every cycle while the output side keeps up. The parser
// captures the 12-byte fixed header, skips 4 bytes per CSRC and, when X is set, reads the
// 4-byte extension header and skips 4 bytes per extension word; empty sections are passed
// over in the same cycle. Header bytes give no result, except a last byte, which gives one
// end result with byte_valid low and a status naming the section left unfinished (0 when
// the header ended exactly). Each payload byte gives one result tagged with the parsed
// header fields; padding is not removed. A result passes from the parser through the
// two-entry queue into the output register; the queue lets the input keep flowing
// while a result waits to be taken, and the input stalls only when the queue is full.
module rtp_header_strip
    import rhs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rhs_in_if.sink    pkt_in,
    rhs_out_if.source pkt_out
);

    rhs_push_t  push;
    logic       q_full;
    logic       q_valid;
    rhs_entry_t q_entry;
    logic       q_pop;
    logic       accept;

    // Take a byte whenever the queue has room for the result it may raise.
    assign pkt_in.ready = !q_full;
    assign accept       = pkt_in.valid && !q_full;

    rhs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (pkt_in.in_byte),
        .last_byte (pkt_in.last_byte),
        .push      (push)
    );

    rhs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (q_pop)
    );

    rhs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (q_pop),
        .tx      (pkt_out)
    );

endmodule

>>> hdl/rhs_checker.sv
// Port-level checks on the RTP header strip, bound to the top level.
module rhs_checker
    import rhs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        o_valid,
    input logic        o_ready,
    input logic [7:0]  o_byte,
    input logic        o_bv,
    input logic        o_eop,
    input logic [2:0]  o_status,
    input logic [15:0] o_seq,
    input logic [31:0] o_ssrc
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> $stable(o_byte) && $stable(o_status) && $stable(o_eop))
        else $error("result changed while stalled");

    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && o_status != ST_OK |-> o_eop && !o_bv)
        else $error("error result must end the packet and carry no byte");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_bv |-> o_eop && o_byte == 8'h00)
        else $error("non-payload result must be an empty end of packet");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && o_status == ST_SHORT_FIXED |-> o_seq == 16'h0 && o_ssrc == 32'h0)
        else $error("short fixed header must report zero fields");

endmodule

bind rtp_header_strip rhs_checker u_rhs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .o_valid  (pkt_out.valid),
    .o_ready  (pkt_out.ready),
    .o_byte   (pkt_out.out_byte),
    .o_bv     (pkt_out.byte_valid),
    .o_eop    (pkt_out.end_of_packet),
    .o_status (pkt_out.status),
    .o_seq    (pkt_out.seq_number),
    .o_ssrc   (pkt_out.source_id)
);
